// ----- rtl/bitmap_first_fit_block_allocator_defines.svh -----
// Assertion macros used by the allocator datapath RTL.
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define BFFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bffa_pkg.sv -----
// Types and constants shared by the allocator modules.
`default_nettype none
package bffa_pkg;

  localparam int ADDR_W      = 64;
  localparam int SIZE_W      = 32;
  localparam int FREED_W     = 13;
  localparam int BLOCK_SHIFT = 5;
  localparam int BLK_W       = ADDR_W - BLOCK_SHIFT;
  localparam int NEED_W      = SIZE_W + 1 - BLOCK_SHIFT;
  localparam int WORD_BITS   = 16;
  localparam int WORD_SHIFT  = 4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_SIZE  = 3'd1,
    ST_NO_RUN     = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  address;
    logic [FREED_W-1:0] freed_blocks;
  } resp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_TABLE,
    S_MARK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    clear;
    logic    load;
    logic    search;
    logic    tab_scan;
    logic    tab_commit;
    logic    mark;
    logic    emit;
    status_t emit_status;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic size_zero;
    logic too_big;
    logic run_hit;
    logic row_last;
    logic tab_hit;
    logic tab_last;
    logic mark_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/bffa_ctrl.sv -----
// Sequencer for clearing, run search, table scan and bitmap update.
`default_nettype none
module bffa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bffa_pkg::dp_stat_t st,
  output bffa_pkg::ctl_t         ctl
);
  import bffa_pkg::*;

  state_t  state, state_next;
  status_t stat, stat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      stat  <= ST_OK;
    end else begin
      state <= state_next;
      stat  <= stat_next;
    end
  end

  always_comb begin
    state_next      = state;
    stat_next       = stat;
    in_stall        = 1'b1;
    ctl             = '0;
    ctl.emit_status = stat;
    unique case (state)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (st.is_free) begin
          state_next = S_TABLE;
        end else if (st.size_zero) begin
          stat_next  = ST_ZERO_SIZE;
          state_next = S_DONE;
        end else if (st.too_big) begin
          stat_next  = ST_NO_RUN;
          state_next = S_DONE;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        ctl.search = 1'b1;
        priority if (st.run_hit) begin
          state_next = S_TABLE;
        end else if (st.row_last) begin
          stat_next  = ST_NO_RUN;
          state_next = S_DONE;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_TABLE: begin
        ctl.tab_scan = 1'b1;
        priority if (st.tab_hit) begin
          ctl.tab_commit = 1'b1;
          state_next     = S_MARK;
        end else if (st.tab_last) begin
          stat_next  = st.is_free ? ST_NOT_FOUND : ST_TABLE_FULL;
          state_next = S_DONE;
        end else begin
          state_next = S_TABLE;
        end
      end
      S_MARK: begin
        ctl.mark = 1'b1;
        if (st.mark_last) begin
          stat_next  = ST_OK;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/bffa_dp.sv -----
// Bitmap and table memories, search logic and result register.
`default_nettype none
module bffa_dp #(
  parameter int NUM_BLOCKS    = 4096,
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bffa_pkg::req_t        req,
  input  wire logic                  cfg_we,
  input  wire logic [bffa_pkg::ADDR_W-1:0] cfg_data,
  input  wire bffa_pkg::ctl_t        ctl,
  output bffa_pkg::dp_stat_t         st,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output bffa_pkg::resp_t            out_data
);
  import bffa_pkg::*;
  `include "bitmap_first_fit_block_allocator_defines.svh"

  localparam int BW    = $clog2(NUM_BLOCKS);
  localparam int CW    = BW + 1;
  localparam int RUN_W = CW + 1;
  localparam int ROWS  = NUM_BLOCKS / WORD_BITS;
  localparam int RW    = $clog2(ROWS);
  localparam int EW    = $clog2(TABLE_ENTRIES);
  localparam int TW    = BW + CW;
  localparam int CLR_N = (ROWS > TABLE_ENTRIES) ? ROWS : TABLE_ENTRIES;
  localparam int CLW   = $clog2(CLR_N);

  logic [WORD_BITS-1:0] map_mem [ROWS];
  logic [TW-1:0]        tab_mem [TABLE_ENTRIES];

  logic [ADDR_W-1:0] heap_base;
  logic [CLW-1:0]    clr_ptr;
  logic [RW-1:0]     row_ptr, row_ptr_next;
  logic [EW-1:0]     ent_ptr, ent_ptr_next;
  logic [WORD_BITS-1:0] map_q;
  logic [TW-1:0]     tab_q;
  logic              is_free, size_zero, too_big, mark_set;
  logic [CW-1:0]     need_q, run_in, cnt_q;
  logic [BLK_W-1:0]  blk_q;
  logic [BW-1:0]     start_q, lo_q, last_q;

  logic [NEED_W-1:0] need_full;
  logic [BW-1:0]     tab_start;
  logic [CW-1:0]     tab_count;
  logic              run_hit;
  logic [WORD_SHIFT-1:0] hit_pos;
  logic [RUN_W-1:0]  run_at [WORD_BITS];
  logic [BW-1:0]     start_calc;
  logic [BW-1:0]     lo_next, last_next;
  logic [CW-1:0]     cnt_next;
  logic              tab_hit;
  logic              map_we, tab_we;
  logic [RW-1:0]     map_waddr;
  logic [EW-1:0]     tab_waddr;
  logic [WORD_BITS-1:0] map_wdata, mark_mask;
  logic [TW-1:0]     tab_wdata;
  logic              clr_map, clr_tab;

  assign need_full = NEED_W'(({1'b0, req.size_bytes} + 33'd31) >> BLOCK_SHIFT);
  assign tab_start = tab_q[TW-1:CW];
  assign tab_count = tab_q[CW-1:0];

  // Free run ending at each bit of the current row, and the lowest bit that completes it.
  always_comb begin
    logic [WORD_BITS-1:0] upto;
    logic                 has;
    logic [WORD_SHIFT-1:0] pos;
    for (int i = 0; i < WORD_BITS; i++) begin
      upto = map_q & WORD_BITS'((32'd2 << i) - 32'd1);
      has  = 1'b0;
      pos  = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
        if (upto[j]) begin
          has = 1'b1;
          pos = WORD_SHIFT'(j);
        end
      end
      run_at[i] = has ? (RUN_W'(i) - RUN_W'(pos))
                      : ({1'b0, run_in} + RUN_W'(i + 1));
    end
    run_hit = 1'b0;
    hit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (run_at[i] >= {1'b0, need_q}) begin
        run_hit = 1'b1;
        hit_pos = WORD_SHIFT'(i);
      end
    end
  end

  assign start_calc = BW'({1'b0, row_ptr, hit_pos} + CW'(1) - need_q);

  assign tab_hit = is_free ? ((tab_count != '0) && (BLK_W'(tab_start) == blk_q))
                           : (tab_count == '0);

  assign lo_next   = is_free ? tab_start : start_q;
  assign cnt_next  = is_free ? tab_count : need_q;
  assign last_next = BW'({1'b0, lo_next} + cnt_next - CW'(1));

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      mark_mask[k] = ({row_ptr, WORD_SHIFT'(k)} >= lo_q) &&
                     ({row_ptr, WORD_SHIFT'(k)} <= last_q);
    end
  end

  always_comb begin
    priority if (ctl.load) begin
      row_ptr_next = '0;
    end else if (ctl.tab_commit) begin
      row_ptr_next = lo_next[BW-1:WORD_SHIFT];
    end else if ((ctl.search && !run_hit) || ctl.mark) begin
      row_ptr_next = row_ptr + 1'b1;
    end else begin
      row_ptr_next = row_ptr;
    end
    priority if (ctl.load) begin
      ent_ptr_next = '0;
    end else if (ctl.tab_scan && !tab_hit) begin
      ent_ptr_next = ent_ptr + 1'b1;
    end else begin
      ent_ptr_next = ent_ptr;
    end
  end

  assign clr_map = ctl.clear && (32'(clr_ptr) < ROWS);
  assign clr_tab = ctl.clear && (32'(clr_ptr) < TABLE_ENTRIES);

  always_comb begin
    map_we    = clr_map || ctl.mark;
    map_waddr = ctl.clear ? clr_ptr[RW-1:0] : row_ptr;
    map_wdata = ctl.clear ? '0 : (mark_set ? (map_q | mark_mask) : (map_q & ~mark_mask));
    tab_we    = clr_tab || ctl.tab_commit;
    tab_waddr = ctl.clear ? clr_ptr[EW-1:0] : ent_ptr;
    tab_wdata = (ctl.clear || is_free) ? '0 : {start_q, need_q};
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_q <= map_mem[row_ptr_next];
  end

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_q <= tab_mem[ent_ptr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
      clr_ptr   <= '0;
      out_valid <= 1'b0;
      row_ptr   <= '0;
      ent_ptr   <= '0;
    end else begin
      if (cfg_we) heap_base <= cfg_data;
      if (ctl.clear) clr_ptr <= clr_ptr + 1'b1;
      row_ptr <= row_ptr_next;
      ent_ptr <= ent_ptr_next;
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      is_free   <= (req.cmd == CMD_FREE);
      size_zero <= (req.size_bytes == '0);
      too_big   <= (need_full > NEED_W'(NUM_BLOCKS));
      need_q    <= need_full[CW-1:0];
      blk_q     <= BLK_W'((req.free_address - heap_base) >> BLOCK_SHIFT);
      run_in    <= '0;
    end
    if (ctl.search) begin
      if (run_hit) begin
        start_q <= start_calc;
      end else begin
        run_in <= run_at[WORD_BITS-1][CW-1:0];
      end
    end
    if (ctl.tab_commit) begin
      lo_q     <= lo_next;
      last_q   <= last_next;
      cnt_q    <= cnt_next;
      mark_set <= !is_free;
    end
    if (ctl.emit) begin
      out_data.status       <= ctl.emit_status;
      out_data.address      <= (ctl.emit_status == ST_OK && !is_free)
                               ? heap_base + (ADDR_W'(start_q) << BLOCK_SHIFT) : '0;
      out_data.freed_blocks <= (ctl.emit_status == ST_OK && is_free)
                               ? FREED_W'(cnt_q) : '0;
    end
  end

  always_comb begin
    st.clr_last  = (clr_ptr == CLW'(CLR_N - 1));
    st.is_free   = is_free;
    st.size_zero = size_zero;
    st.too_big   = too_big;
    st.run_hit   = run_hit;
    st.row_last  = (row_ptr == RW'(ROWS - 1));
    st.tab_hit   = tab_hit;
    st.tab_last  = (ent_ptr == EW'(TABLE_ENTRIES - 1));
    st.mark_last = (row_ptr == last_q[BW-1:WORD_SHIFT]);
    st.out_free  = !out_valid || !out_stall;
  end

  `BFFA_ASSERT_NOW(a_one_op, 1'b1, $onehot0({ctl.clear, ctl.search, ctl.tab_scan, ctl.mark}), "more than one datapath operation at once")
  `BFFA_ASSERT_NOW(a_mark_range, ctl.mark, row_ptr <= last_q[BW-1:WORD_SHIFT], "bitmap update ran past the last row")
  `BFFA_ASSERT_NOW(a_emit_slot, ctl.emit, !out_valid || !out_stall, "result written over a waiting item")
  `BFFA_ASSERT_NEXT(a_alloc_need, ctl.tab_commit && !is_free, tab_mem[ent_ptr] != '0, "allocation recorded an empty entry")

endmodule
`default_nettype wire

// ----- rtl/bitmap_first_fit_block_allocator.sv -----
// Top level of the bitmap first-fit block allocator.
//
//   port group  direction  handshake          item
//   in_*        in         in_valid/in_stall  req_t: cmd, size_bytes, free_address
//   out_*       out        out_valid/out_stall resp_t: status, address, freed_blocks
//   cfg_*       in         cfg_valid/cfg_ready heap_base write data
//
// One item is worked at a time. An allocate scans the bitmap row by row (16 blocks a
// row) for the first free run that fits, then scans the table for its first empty
// entry and marks the run's rows used; a free scans the table for the entry that
// matches its address and clears that run's rows. After reset a clearing pass over
// max(NUM_BLOCKS/16, TABLE_ENTRIES) addresses zeroes both memories; no item is
// taken during it. A stalled result waits in the output register while the next
// item is already accepted; that item finishes once the result leaves.
`default_nettype none
module bitmap_first_fit_block_allocator #(
  parameter int NUM_BLOCKS    = 4096,
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire bffa_pkg::req_t               in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output bffa_pkg::resp_t                   out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bffa_pkg::ADDR_W-1:0]  cfg_data
);
  import bffa_pkg::*;

  ctl_t     ctl;
  dp_stat_t st;

  // Write the base register only while the block is idle; not enforced, so always ready.
  assign cfg_ready = 1'b1;

  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  bffa_dp #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- tb/bitmap_first_fit_block_allocator_test.sv -----
// Self-checking testbench for the bitmap first-fit block allocator.
`default_nettype none
module bitmap_first_fit_block_allocator_test;
  import bffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 4096;
  localparam int NTAB = 256;
  localparam int BLK_BYTES = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  resp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ADDR_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  bitmap_first_fit_block_allocator #(.NUM_BLOCKS(NBLK), .TABLE_ENTRIES(NTAB)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the heap state that the predictor works on.
  logic [63:0] shadow_base;
  bit used_bits[NBLK];
  int unsigned slot_start[NTAB];
  int unsigned slot_count[NTAB];

  // Addresses of live allocations, so that frees mostly hit real blocks.
  logic [63:0] live_addrs[$];

  req_t pending_reqs[$];
  resp_t expected_resps[$];

  int errors = 0;
  int checked = 0;
  int n_alloc_ok = 0, n_free_ok = 0, n_errs = 0;

  // Predict the response for one accepted request and update the shadow state.
  function automatic resp_t predict_response(req_t r);
    resp_t res;
    logic [32:0] need;
    int run, start, slot, e;
    bit found;
    logic [63:0] blk;
    res = '0;
    res.status = ST_OK;
    if (r.cmd == CMD_ALLOC) begin
      if (r.size_bytes == 0) begin
        res.status = ST_ZERO_SIZE;
        return res;
      end
      need = ({1'b0, r.size_bytes} + 33'd31) >> 5;
      if (need > NBLK) begin
        res.status = ST_NO_RUN;
        return res;
      end
      run = 0;
      found = 0;
      start = 0;
      for (int i = 0; i < NBLK; i++) begin
        if (used_bits[i]) begin
          run = 0;
        end else begin
          run++;
          if (run == need) begin
            start = i + 1 - int'(need);
            found = 1;
            break;
          end
        end
      end
      if (!found) begin
        res.status = ST_NO_RUN;
        return res;
      end
      slot = NTAB;
      for (int s = 0; s < NTAB; s++) begin
        if (slot_count[s] == 0) begin
          slot = s;
          break;
        end
      end
      if (slot == NTAB) begin
        res.status = ST_TABLE_FULL;
        return res;
      end
      slot_start[slot] = start;
      slot_count[slot] = need;
      for (int i = start; i < start + int'(need); i++) used_bits[i] = 1;
      res.address = shadow_base + 64'(start) * BLK_BYTES;
    end else begin
      blk = (r.free_address - shadow_base) >> 5;
      e = NTAB;
      for (int s = 0; s < NTAB; s++) begin
        if (slot_count[s] != 0 && 64'(slot_start[s]) == blk) begin
          e = s;
          break;
        end
      end
      if (e == NTAB) begin
        res.status = ST_NOT_FOUND;
        return res;
      end
      for (int i = slot_start[e]; i < slot_start[e] + slot_count[e] && i < NBLK; i++)
        used_bits[i] = 0;
      res.freed_blocks = slot_count[e][FREED_W-1:0];
      slot_start[e] = 0;
      slot_count[e] = 0;
    end
    return res;
  endfunction

  // Driver: bursts of valid items separated by random gaps.
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_resps.push_back(predict_response(in_data));
        void'(pending_reqs.pop_front());
      end
      // Decide what is on the bus for the next edge; one assignment per signal.
      if (in_valid && in_stall) begin
        // A stalled item stays put.
      end else if (pending_reqs.size() > 0 && gap_left == 0) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs[0];
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Receiver: random stall pattern, with one long hold-off forced by the stimulus.
  int stall_mode = 0;
  int long_hold = 0;
  always @(posedge clk) begin
    if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Monitor: compare every accepted response with the oldest prediction.
  always @(posedge clk) begin
    resp_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_resps.size() == 0) begin
        $error("response with none expected: status %0d", out_data.status);
        errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        checked++;
        if (out_data.status != exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, out_data.status);
          errors++;
        end
        if (out_data.address != exp_r.address) begin
          $error("address: expected %h actual %h", exp_r.address, out_data.address);
          errors++;
        end
        if (out_data.freed_blocks != exp_r.freed_blocks) begin
          $error("freed_blocks: expected %0d actual %0d", exp_r.freed_blocks,
                 out_data.freed_blocks);
          errors++;
        end
        if (exp_r.status == ST_OK && exp_r.freed_blocks == 0) begin
          n_alloc_ok++;
          live_addrs.push_back(exp_r.address);
        end else if (exp_r.status == ST_OK) begin
          n_free_ok++;
        end else begin
          n_errs++;
        end
      end
    end
  end

  function automatic req_t mk_alloc(logic [31:0] sz);
    req_t r;
    r = '0;
    r.cmd = CMD_ALLOC;
    r.size_bytes = sz;
    r.free_address = {$urandom, $urandom};
    return r;
  endfunction

  function automatic req_t mk_free(logic [63:0] a);
    req_t r;
    r = '0;
    r.cmd = CMD_FREE;
    r.free_address = a;
    r.size_bytes = $urandom;
    return r;
  endfunction

  // Wait until every queued item is sent and every response has come back.
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_resps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_base(logic [63:0] b);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= b;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_base = b;
  endtask

  // Picks a size: mostly small, sometimes large, rarely the heap's edge.
  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 19))
      0: return 32'($urandom_range(4000, 4096) * 32 - $urandom_range(0, 31));
      1: return $urandom;
      2: return 0;
      3, 4: return $urandom_range(1, 2048);
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  // Random phase: mostly allocations, some well-formed frees of live blocks, plus noise.
  task automatic random_phase(int n);
    int k;
    logic [63:0] a;
    for (int i = 0; i < n; i++) begin
      if (live_addrs.size() > 0 && $urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[k] + $urandom_range(0, 31);
        live_addrs.delete(k);
        pending_reqs.push_back(mk_free(a));
      end else if ($urandom_range(0, 15) == 0) begin
        pending_reqs.push_back(mk_free({$urandom, $urandom}));
      end else begin
        pending_reqs.push_back(mk_alloc(rand_size()));
      end
      // Keep the queue short so frees see fresh live addresses.
      while (pending_reqs.size() > 4) @(posedge clk);
    end
  endtask

  initial begin : timeout_guard
    #40ms;
    $display("** bitmap_first_fit_block_allocator: FAILED **");
    $finish;
  end

  initial begin
    for (int i = 0; i < NBLK; i++) used_bits[i] = 0;
    for (int i = 0; i < NTAB; i++) begin
      slot_start[i] = 0;
      slot_count[i] = 0;
    end
    shadow_base = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: every status but table-full, and the field extremes at the reset base.
    pending_reqs.push_back(mk_alloc(32'd0));
    pending_reqs.push_back(mk_alloc(32'd1));
    pending_reqs.push_back(mk_alloc(32'd32));
    pending_reqs.push_back(mk_alloc(32'd33));
    pending_reqs.push_back(mk_alloc(32'hFFFF_FFFF));
    pending_reqs.push_back(mk_alloc(32'd131073));
    pending_reqs.push_back(mk_free(64'd31));
    pending_reqs.push_back(mk_free(64'd32));
    pending_reqs.push_back(mk_free(64'd32));
    pending_reqs.push_back(mk_free(64'hFFFF_FFFF_FFFF_FFFF));
    pending_reqs.push_back(mk_free(64'd64 + 64'd17));
    pending_reqs.push_back(mk_free(64'd1 << 20));
    pending_reqs.push_back(mk_alloc(32'd131072 - 32'd96));
    pending_reqs.push_back(mk_alloc(32'd64));
    pending_reqs.push_back(mk_free(64'd96));
    pending_reqs.push_back(mk_alloc(32'd64));
    drain();
    live_addrs.delete();

    // Fill the table with single blocks so the table-full status shows up.
    write_base(64'hFFFF_FFFF_FFFF_FF00);
    for (int i = 0; i < 3; i++) pending_reqs.push_back(mk_free(64'hFFFF_FFFF_FFFF_FF00
                                                               + 64'(i) * 32));
    for (int i = 0; i < NTAB + 2; i++) pending_reqs.push_back(mk_alloc(32'd1));
    pending_reqs.push_back(mk_free(64'd0));
    drain();

    // Long receiver hold-off while the sender keeps offering items.
    long_hold = 300;
    for (int i = 0; i < 20; i++) pending_reqs.push_back(mk_alloc(32'd1));
    drain();

    // Release everything by freeing each live address.
    while (live_addrs.size() > 0) pending_reqs.push_back(mk_free(live_addrs.pop_front()));
    drain();

    // Random phases at several bases, extremes among them.
    write_base(64'h0000_0000_0010_0000);
    random_phase(130);
    drain();
    write_base({$urandom, $urandom});
    random_phase(130);
    drain();
    write_base(64'hFFFF_FFFF_FFFF_FFE0);
    random_phase(130);
    drain();

    $display("checked %0d responses: %0d allocations, %0d frees, %0d error statuses",
             checked, n_alloc_ok, n_free_ok, n_errs);
    if (errors == 0) begin
      $display("** bitmap_first_fit_block_allocator: PASSED **");
    end else begin
      $display("** bitmap_first_fit_block_allocator: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
